>>> sv/fpa_pkg.sv
`default_nettype none

package fpa_pkg;

   // raw operand and result width
   localparam int WORD_W = 32;

   // opcode field of an input item
   typedef enum logic [3:0] {
      OP_ADD      = 4'd0,
      OP_SUB      = 4'd1,
      OP_MUL      = 4'd2,
      OP_DIV      = 4'd3,
      OP_INC      = 4'd4,
      OP_DEC      = 4'd5,
      OP_MIN      = 4'd6,
      OP_MAX      = 4'd7,
      OP_GT       = 4'd8,
      OP_GE       = 4'd9,
      OP_LT       = 4'd10,
      OP_LE       = 4'd11,
      OP_EQ       = 4'd12,
      OP_NE       = 4'd13,
      OP_FROM_INT = 4'd14,
      OP_TO_INT   = 4'd15
   } op_type;

endpackage

`default_nettype wire

>>> sv/fixed_point_alu_unit.sv
`default_nettype none

// Channel | Direction | Contents
// req     | in        | tdata: op[3:0], operand_a[35:4], operand_b[67:36], zero pad
// rsp     | out       | tdata: result_value[31:0], compare_true, overflow,
//         |           |        divide_by_zero, zero pad
//
// Every opcode passes through the input stage, the divider stages and the output
// register; one item enters per cycle unless rsp stalls. The depth is set by the divider: one quotient bit per stage.
// Synchronous reset clears all valid bits; payload registers are not reset.
// A stall at rsp freezes the whole pipe, so req_tready follows it.
module fixed_point_alu_unit #(
   parameter int FRAC_BITS = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [71:0] req_tdata,   // op, operand_a, operand_b
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata    // result_value, compare_true, overflow, divide_by_zero
);
   import fpa_pkg::*;

   localparam int QW = WORD_W + FRAC_BITS;   // dividend and quotient width
   localparam int MW = 2 * WORD_W + 1;       // wide magnitude for saturation

   typedef struct packed {
      op_type              op;
      logic [WORD_W-1:0]   res;
      logic                cmp;
      logic                ovf;
      logic                dbz;
      logic [2*WORD_W-1:0] prod;
      logic                neg;
      logic [QW-1:0]       num;
      logic [WORD_W-1:0]   den;
   } side_type;

   // clamp a magnitude with a sign to 32 signed bits, {ovf, value}
   function automatic logic [WORD_W:0] sat_mag(input logic [MW-1:0] mag, input logic neg);
      logic [MW-1:0] lim;
      logic [WORD_W-1:0] v;
      lim = MW'(1) << (WORD_W - 1);
      v   = mag[WORD_W-1:0];
      if (neg) begin
         if (mag > lim) return {1'b1, 1'b1, {(WORD_W-1){1'b0}}};
         return {1'b0, WORD_W'(0) - v};
      end
      if (mag > lim - MW'(1)) return {1'b1, 1'b0, {(WORD_W-1){1'b1}}};
      return {1'b0, v};
   endfunction

   logic en;
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   // input stage
   logic                     a_vld_ff;
   op_type                   a_op_ff;
   logic signed [WORD_W-1:0] a_a_ff, a_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (en) begin
         a_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_op_ff <= op_type'(req_tdata[3:0]);
         a_a_ff  <= req_tdata[35:4];
         a_b_ff  <= req_tdata[67:36];
      end
   end

   // simple ops, magnitudes and product
   side_type                   b_in;
   logic signed [WORD_W:0]     sum_w, dif_w, inc_w, dec_w;
   logic signed [2*WORD_W-1:0] shl_w;
   logic [WORD_W-1:0]          mag_a, mag_b;
   logic [WORD_W:0]            sat_tmp;

   always_comb begin
      sum_w = {a_a_ff[WORD_W-1], a_a_ff} + {a_b_ff[WORD_W-1], a_b_ff};
      dif_w = {a_a_ff[WORD_W-1], a_a_ff} - {a_b_ff[WORD_W-1], a_b_ff};
      inc_w = {a_a_ff[WORD_W-1], a_a_ff} + (WORD_W+1)'(1);
      dec_w = {a_a_ff[WORD_W-1], a_a_ff} - (WORD_W+1)'(1);
      shl_w = (2*WORD_W)'(a_a_ff) <<< FRAC_BITS;
      mag_a = a_a_ff[WORD_W-1] ? WORD_W'(0) - a_a_ff : a_a_ff;
      mag_b = a_b_ff[WORD_W-1] ? WORD_W'(0) - a_b_ff : a_b_ff;
      sat_tmp = '0;

      b_in      = '0;
      b_in.op   = a_op_ff;
      b_in.prod = mag_a * mag_b;
      b_in.neg  = a_a_ff[WORD_W-1] ^ a_b_ff[WORD_W-1];
      b_in.num  = {mag_a, {FRAC_BITS{1'b0}}};
      b_in.den  = mag_b;
      b_in.dbz  = (a_op_ff == OP_DIV) && (a_b_ff == '0);

      case (a_op_ff)
         OP_ADD: begin
            b_in.ovf = sum_w[WORD_W] != sum_w[WORD_W-1];
            b_in.res = b_in.ovf ? {sum_w[WORD_W], {(WORD_W-1){~sum_w[WORD_W]}}}
                                : sum_w[WORD_W-1:0];
         end
         OP_SUB: begin
            b_in.ovf = dif_w[WORD_W] != dif_w[WORD_W-1];
            b_in.res = b_in.ovf ? {dif_w[WORD_W], {(WORD_W-1){~dif_w[WORD_W]}}}
                                : dif_w[WORD_W-1:0];
         end
         OP_INC: begin
            b_in.ovf = inc_w[WORD_W] != inc_w[WORD_W-1];
            b_in.res = b_in.ovf ? {inc_w[WORD_W], {(WORD_W-1){~inc_w[WORD_W]}}}
                                : inc_w[WORD_W-1:0];
         end
         OP_DEC: begin
            b_in.ovf = dec_w[WORD_W] != dec_w[WORD_W-1];
            b_in.res = b_in.ovf ? {dec_w[WORD_W], {(WORD_W-1){~dec_w[WORD_W]}}}
                                : dec_w[WORD_W-1:0];
         end
         OP_MIN:  b_in.res = (a_a_ff < a_b_ff) ? a_a_ff : a_b_ff;
         OP_MAX:  b_in.res = (a_a_ff > a_b_ff) ? a_a_ff : a_b_ff;
         OP_GT:   b_in.cmp = a_a_ff > a_b_ff;
         OP_GE:   b_in.cmp = a_a_ff >= a_b_ff;
         OP_LT:   b_in.cmp = a_a_ff < a_b_ff;
         OP_LE:   b_in.cmp = a_a_ff <= a_b_ff;
         OP_EQ:   b_in.cmp = a_a_ff == a_b_ff;
         OP_NE:   b_in.cmp = a_a_ff != a_b_ff;
         OP_FROM_INT: begin
            sat_tmp  = sat_mag(a_a_ff[WORD_W-1] ? MW'(-shl_w) : MW'(shl_w),
                               a_a_ff[WORD_W-1]);
            b_in.ovf = sat_tmp[WORD_W];
            b_in.res = sat_tmp[WORD_W-1:0];
         end
         OP_TO_INT: b_in.res = a_a_ff >>> FRAC_BITS;
         default: begin
            b_in.res = '0;
         end
      endcase
   end

   // side pipe along the divider stages
   logic     vld_ff  [0:QW];
   side_type side_ff [0:QW];
   logic [WORD_W-1:0] rem_w [0:QW];
   logic [QW-1:0]     quo_w [0:QW];

   assign rem_w[0] = '0;
   assign quo_w[0] = '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= a_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= b_in;
      end
   end

   for (genvar i = 0; i < QW; i++) begin : g_div
      fpa_div_stage #(.QUO_W(QW)) u_stage (
         .clock   (clock),
         .en      (en),
         .rem_i   (rem_w[i]),
         .quo_i   (quo_w[i]),
         .num_bit (side_ff[i].num[QW-1-i]),
         .den     (side_ff[i].den),
         .rem_o   (rem_w[i+1]),
         .quo_o   (quo_w[i+1])
      );

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i+1] <= 1'b0;
         end else if (en) begin
            vld_ff[i+1] <= vld_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            side_ff[i+1] <= side_ff[i];
         end
      end
   end

   // rounding, saturation and result select
   side_type          last;
   logic [MW-1:0]     mul_mag, div_mag;
   logic [WORD_W:0]   mul_sat, div_sat;
   logic              rnd_up;
   logic [WORD_W-1:0] res_in;
   logic              ovf_in;

   always_comb begin
      last    = side_ff[QW];
      mul_mag = (MW'(last.prod) + (MW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
      mul_sat = sat_mag(mul_mag, last.neg);
      rnd_up  = ({rem_w[QW], 1'b0} >= {1'b0, last.den});
      div_mag = MW'(quo_w[QW]) + MW'(rnd_up);
      div_sat = sat_mag(div_mag, last.neg);
      case (last.op)
         OP_MUL: begin
            res_in = mul_sat[WORD_W-1:0];
            ovf_in = mul_sat[WORD_W];
         end
         OP_DIV: begin
            res_in = last.dbz ? '0 : div_sat[WORD_W-1:0];
            ovf_in = last.dbz ? 1'b0 : div_sat[WORD_W];
         end
         default: begin
            res_in = last.res;
            ovf_in = last.ovf;
         end
      endcase
   end

   // output register
   logic              rsp_vld_ff;
   logic [WORD_W-1:0] rsp_res_ff;
   logic              rsp_cmp_ff, rsp_ovf_ff, rsp_dbz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (en) begin
         rsp_vld_ff <= vld_ff[QW];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_res_ff <= res_in;
         rsp_cmp_ff <= last.cmp;
         rsp_ovf_ff <= ovf_in;
         rsp_dbz_ff <= last.dbz;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {5'b0, rsp_dbz_ff, rsp_ovf_ff, rsp_cmp_ff, rsp_res_ff};

endmodule

`default_nettype wire

>>> sv/fpa_div_stage.sv
`default_nettype none

// One restoring-division step: shift in one dividend bit, try to subtract
// the divisor, record one quotient bit.
module fpa_div_stage #(
   parameter int QUO_W = 40
) (
   input  wire logic                        clock,
   input  wire logic                        en,
   input  wire logic [fpa_pkg::WORD_W-1:0]  rem_i,
   input  wire logic [QUO_W-1:0]            quo_i,
   input  wire logic                        num_bit,
   input  wire logic [fpa_pkg::WORD_W-1:0]  den,
   output logic      [fpa_pkg::WORD_W-1:0]  rem_o,
   output logic      [QUO_W-1:0]            quo_o
);
   import fpa_pkg::*;

   logic [WORD_W:0]   trial;
   logic [WORD_W:0]   diff;
   logic              fits;
   logic [WORD_W-1:0] rem_ff, rem_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;

   // trial subtract
   always_comb begin
      trial  = {rem_i, num_bit};
      diff   = trial - {1'b0, den};
      fits   = (trial >= {1'b0, den});
      rem_in = fits ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
      quo_in = {quo_i[QUO_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign rem_o = rem_ff;
   assign quo_o = quo_ff;

endmodule

`default_nettype wire

>>> tb/fixed_point_alu_unit_tb.sv
`default_nettype none

module fixed_point_alu_unit_tb;
   import fpa_pkg::*;

   localparam int FRAC     = 8;
   localparam int LATENCY  = 32 + FRAC + 3;
   localparam longint MAXV = 64'sd2147483647;
   localparam longint MINV = -64'sd2147483648;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [31:0] value;
      logic        cmp;
      logic        ovf;
      logic        dbz;
   } alu_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;   // op, operand_a, operand_b
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // result_value, compare_true, overflow, divide_by_zero

   alu_result_type pending_results[$];
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   int          cycle_count = 0;
   bit          failed = 1'b0;

   fixed_point_alu_unit #(.FRAC_BITS(FRAC)) dut (.*);

   always #5 clock = ~clock;

   // clamp to 32 signed bits
   function automatic logic [31:0] clamp32(input longint v, inout logic ovf);
      if (v > MAXV) begin
         ovf = 1'b1;
         return MAXV[31:0];
      end
      if (v < MINV) begin
         ovf = 1'b1;
         return MINV[31:0];
      end
      return v[31:0];
   endfunction

   // expected result of one operation
   function automatic alu_result_type alu_predict(input op_type op, input logic [31:0] ra,
                                                  input logic [31:0] rb);
      alu_result_type r;
      longint a, b, p;
      logic [63:0] mag, n, d, q, rem;
      logic ovf;
      a = longint'(signed'(ra));
      b = longint'(signed'(rb));
      r = '0;
      ovf = 1'b0;
      case (op)
         OP_ADD: r.value = clamp32(a + b, ovf);
         OP_SUB: r.value = clamp32(a - b, ovf);
         OP_MUL: begin
            p = a * b;
            mag = (p < 0) ? -p : p;
            mag = (mag + (64'd1 << (FRAC - 1))) >> FRAC;
            r.value = clamp32((p < 0) ? -longint'(mag) : longint'(mag), ovf);
         end
         OP_DIV: begin
            if (b == 0) begin
               r.dbz = 1'b1;
            end else begin
               n = ((a < 0) ? -a : a) << FRAC;
               d = (b < 0) ? -b : b;
               q = n / d;
               rem = n % d;
               if (2 * rem >= d) q++;
               r.value = clamp32(((a < 0) != (b < 0)) ? -longint'(q) : longint'(q), ovf);
            end
         end
         OP_INC: r.value = clamp32(a + 1, ovf);
         OP_DEC: r.value = clamp32(a - 1, ovf);
         OP_MIN: r.value = (a < b) ? ra : rb;
         OP_MAX: r.value = (a > b) ? ra : rb;
         OP_GT: r.cmp = a > b;
         OP_GE: r.cmp = a >= b;
         OP_LT: r.cmp = a < b;
         OP_LE: r.cmp = a <= b;
         OP_EQ: r.cmp = a == b;
         OP_NE: r.cmp = a != b;
         OP_FROM_INT: r.value = clamp32(a * (64'sd1 << FRAC), ovf);
         default: r.value = 32'(signed'(ra) >>> FRAC);
      endcase
      r.ovf = ovf;
      return r;
   endfunction

   // send one item, with random idle cycles before it
   task automatic send_op(input op_type op, input logic [31:0] a, input logic [31:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {4'b0, b, a, op};
      pending_results.push_back(alu_predict(op, a, b));
      do @(posedge clock); while (!req_tready);
   endtask

   // receiver stalls and result check
   always @(posedge clock) begin
      alu_result_type got, want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.value = rsp_tdata[31:0];
            got.cmp   = rsp_tdata[32];
            got.ovf   = rsp_tdata[33];
            got.dbz   = rsp_tdata[34];
            if (pending_results.size() == 0) begin
               $display("%0t: unexpected result %h", $time, got);
               failed = 1'b1;
            end else begin
               want = pending_results.pop_front();
               if (got != want) begin
                  $display("%0t: mismatch expected val=%h cmp=%b ovf=%b dbz=%b",
                           $time, want.value, want.cmp, want.ovf, want.dbz);
                  $display("%0t:          actual   val=%h cmp=%b ovf=%b dbz=%b",
                           $time, got.value, got.cmp, got.ovf, got.dbz);
                  failed = 1'b1;
               end
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic logic [31:0] pick_operand();
      case ($urandom_range(7))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return $urandom_range(2) - 1;
         3: return 32'($signed($urandom_range(4096)) - 2048);
         4: return 32'($signed($urandom_range(1 << 20)) - (1 << 19));
         default: return $urandom;
      endcase
   endfunction

   task automatic test_extremes();
      op_type op;
      for (int i = 0; i < 16; i++) begin
         op = op_type'(i);
         send_op(op, 32'h7fffffff, 32'h7fffffff);
      end
      send_op(OP_ADD, 32'h80000000, 32'h80000000);
      send_op(OP_SUB, 32'h80000000, 32'h00000001);
      send_op(OP_MUL, 32'h80000000, 32'h80000000);
      send_op(OP_MUL, 32'hffffff80, 32'h00000001);   // -0.5 rounds away from zero
      send_op(OP_DIV, 32'h00000100, 32'h00000000);   // zero divisor
      send_op(OP_DIV, 32'h80000000, 32'h00000001);
      send_op(OP_DIV, 32'h00000001, 32'h00000200);   // half quotient
      send_op(OP_DEC, 32'h80000000, 32'h0);
      send_op(OP_TO_INT, 32'h80000000, 32'h0);
      send_op(OP_FROM_INT, 32'h80000000, 32'h0);
      send_op(OP_MIN, 32'h5, 32'h5);
   endtask

   task automatic test_random(input int count);
      for (int i = 0; i < count; i++)
         send_op(op_type'($urandom_range(15)), pick_operand(), pick_operand());
   endtask

   task automatic drain();
      int waited;
      waited = 0;
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      send_idle_pct = 30;
      recv_stall_pct = 54;
      test_random(230);
      send_idle_pct = 54;
      recv_stall_pct = 30;
      test_random(230);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      test_random(240);
      drain();
      if (!failed && pending_results.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

`default_nettype wire
